// File: hw/rtl/rfrfc_pkg.sv
// ----------------------------------------------------------------------------
// Remapped frame read package
// Shared types, register indexes, format codes and the byte conversion table.
// ----------------------------------------------------------------------------
package rfrfc_pkg;

   localparam int POS_W      = 8;
   localparam int PIXEL_W    = 64;
   localparam int SIZE_W     = 9;
   localparam int OFFSET_W   = 9;
   localparam int STEP_W     = 24;
   localparam int FMT_W      = 2;
   localparam int PROD_W     = POS_W + STEP_W;
   localparam int FRAC_W     = 16;
   localparam int COORD_W    = PROD_W - FRAC_W + 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int BYTES      = PIXEL_W / 8;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // bytes per pixel
   localparam logic [FMT_W-1:0] FMT_3B = 2'd0;
   localparam logic [FMT_W-1:0] FMT_4B = 2'd1;
   localparam logic [FMT_W-1:0] FMT_6B = 2'd2;
   localparam logic [FMT_W-1:0] FMT_8B = 2'd3;

   localparam logic [SIZE_W-1:0]   RST_SRC_WIDTH  = 9'd256;
   localparam logic [SIZE_W-1:0]   RST_SRC_HEIGHT = 9'd256;
   localparam logic [FMT_W-1:0]    RST_SRC_FORMAT = FMT_4B;
   localparam logic [FMT_W-1:0]    RST_DST_FORMAT = FMT_4B;
   localparam logic [OFFSET_W-1:0] RST_OFFSET     = 9'd0;
   localparam logic [STEP_W-1:0]   RST_STEP       = 24'd65536;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 4'd0,
      REG_SRC_HEIGHT = 4'd1,
      REG_SRC_FORMAT = 4'd2,
      REG_DST_FORMAT = 4'd3,
      REG_OFFSET_X   = 4'd4,
      REG_OFFSET_Y   = 4'd5,
      REG_STEP_X     = 4'd6,
      REG_STEP_Y     = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]          src_width;
      logic [SIZE_W-1:0]          src_height;
      logic [FMT_W-1:0]           src_format;
      logic [FMT_W-1:0]           dst_format;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [STEP_W-1:0]          step_x;
      logic [STEP_W-1:0]          step_y;
   } cfg_type;

   // byte selector codes: 0..7 pick a source byte
   localparam logic [3:0] SEL_ZERO = 4'd8;
   localparam logic [3:0] SEL_FILL = 4'd9;

   // indexed [dst_format][src_format][result byte]
   localparam logic [3:0] CONV_TAB [4][4][8] = '{
      '{ '{4'd0, 4'd1, 4'd2, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd1, 4'd2, 4'd3, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd0, 4'd2, 4'd4, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd2, 4'd4, 4'd6, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO} },
      '{ '{SEL_FILL, 4'd0, 4'd1, 4'd2, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd0, 4'd1, 4'd2, 4'd3, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{SEL_FILL, 4'd0, 4'd2, 4'd4, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd0, 4'd2, 4'd4, 4'd6, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO} },
      '{ '{4'd0, SEL_ZERO, 4'd1, SEL_ZERO, 4'd2, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd1, SEL_ZERO, 4'd2, SEL_ZERO, 4'd3, SEL_ZERO, SEL_ZERO, SEL_ZERO},
         '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, SEL_ZERO, SEL_ZERO},
         '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, SEL_ZERO, SEL_ZERO} },
      '{ '{SEL_FILL, SEL_FILL, 4'd0, SEL_ZERO, 4'd1, SEL_ZERO, 4'd2, SEL_ZERO},
         '{4'd0, SEL_ZERO, 4'd1, SEL_ZERO, 4'd2, SEL_ZERO, 4'd3, SEL_ZERO},
         '{SEL_FILL, SEL_FILL, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5},
         '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7} }
   };

   function automatic logic [PIXEL_W-1:0] conv_pixel(
      input logic [PIXEL_W-1:0] src,
      input logic [FMT_W-1:0]   src_fmt,
      input logic [FMT_W-1:0]   dst_fmt
   );
      logic [PIXEL_W-1:0] res;
      logic [3:0]         code;
      res = '0;
      for (int k = 0; k < BYTES; k++) begin
         code = CONV_TAB[dst_fmt][src_fmt][k];
         if (code == SEL_ZERO) begin
            res[8*k +: 8] = 8'h00;
         end else if (code == SEL_FILL) begin
            res[8*k +: 8] = 8'hFF;
         end else begin
            res[8*k +: 8] = src[8*code[2:0] +: 8];
         end
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/rfrfc_if.sv
// ----------------------------------------------------------------------------
// Remapped frame read channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface rfrfc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [rfrfc_pkg::POS_W-1:0]    pos_x;
   logic [rfrfc_pkg::POS_W-1:0]    pos_y;
   logic [rfrfc_pkg::PIXEL_W-1:0]  pixel_in;

   modport source (output valid, cmd, pos_x, pos_y, pixel_in, input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, pixel_in, output ready);
endinterface

interface rfrfc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rfrfc_pkg::PIXEL_W-1:0]  pixel_out;
   logic                           outside;

   modport source (output valid, pixel_out, outside, input ready);
   modport sink   (input valid, pixel_out, outside, output ready);
endinterface

interface rfrfc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rfrfc_pkg::CSR_IDX_W-1:0]   index;
   logic [rfrfc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/remapped_frame_read_with_format_convert_core.sv
// ----------------------------------------------------------------------------
// Remapped frame read with format convert
// Frame store with crop / nearest-neighbour remapped reads and pixel format
// conversion.
// ----------------------------------------------------------------------------
// Write transactions store a 64-bit pixel at (pos_x, pos_y); read
// transactions map (pos_x, pos_y) to source column offset_x +
// floor(pos_x * step_x) and row offset_y + floor(pos_y * step_y) in Q8.16,
// return zero with outside set when that lands off the source image, and
// otherwise return the stored pixel converted from src_format to dst_format.
// One transaction of either kind is accepted per clock unless a stalled
// response holds the pipeline; a read response passes through the step
// multiply, frame memory read and format conversion registers, and a write
// uses the single frame memory port and gives no response. Reads and writes
// reach the memory in acceptance order, so a read sees every earlier write.
// The frame store has no reset: an entry reads as undefined until written.
// The user writes registers only while no transaction is in flight; unchecked.
// ----------------------------------------------------------------------------
module remapped_frame_read_with_format_convert_core #(
   parameter int MAX_WIDTH  = rfrfc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rfrfc_pkg::DEF_MAX_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   rfrfc_req_if.sink    req_ch,
   rfrfc_rsp_if.source  rsp_ch,
   rfrfc_csr_if.sink    csr_ch
);
   import rfrfc_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);

   cfg_type cfg;

   rfrfc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   logic [PIXEL_W-1:0] frame_store_ff [DEPTH];

   logic               s1_vld_ff, s1_vld_in;
   logic               s1_cmd_ff, s1_cmd_in;
   logic [POS_W-1:0]   s1_px_ff, s1_px_in;
   logic [POS_W-1:0]   s1_py_ff, s1_py_in;
   logic [PIXEL_W-1:0] s1_pix_ff, s1_pix_in;
   logic [PROD_W-1:0]  s1_prodx_ff, s1_prodx_in;
   logic [PROD_W-1:0]  s1_prody_ff, s1_prody_in;

   logic               s2_vld_ff, s2_vld_in;
   logic               s2_out_ff, s2_out_in;
   logic [PIXEL_W-1:0] rd_ff;

   logic               o_vld_ff, o_vld_in;
   logic               o_out_ff, o_out_in;
   logic [PIXEL_W-1:0] o_pix_ff, o_pix_in;

   logic               out_free, move2, s2_free, move1, s1_free, accept;
   logic               s1_read;
   logic [COORD_W-1:0] col, row, lim_w, lim_h;
   logic               outside;
   logic               wr_ok;
   logic [CW-1:0]      col_idx;
   logic [RW-1:0]      row_idx;
   logic [AW-1:0]      addr;
   logic               mem_wr, mem_rd;

   // handshake chain
   assign out_free = !o_vld_ff || rsp_ch.ready;
   assign move2    = s2_vld_ff && out_free;
   assign s2_free  = !s2_vld_ff || move2;
   assign move1    = s1_vld_ff && s2_free;
   assign s1_free  = !s1_vld_ff || move1;
   assign accept   = req_ch.valid && s1_free;

   assign req_ch.ready     = s1_free;
   assign rsp_ch.valid     = o_vld_ff;
   assign rsp_ch.pixel_out = o_pix_ff;
   assign rsp_ch.outside   = o_out_ff;

   // stage 1: step products
   always_comb begin
      s1_vld_in   = accept || (s1_vld_ff && !move1);
      s1_cmd_in   = s1_cmd_ff;
      s1_px_in    = s1_px_ff;
      s1_py_in    = s1_py_ff;
      s1_pix_in   = s1_pix_ff;
      s1_prodx_in = s1_prodx_ff;
      s1_prody_in = s1_prody_ff;
      if (accept) begin
         s1_cmd_in   = req_ch.cmd;
         s1_px_in    = req_ch.pos_x;
         s1_py_in    = req_ch.pos_y;
         s1_pix_in   = req_ch.pixel_in;
         s1_prodx_in = PROD_W'(req_ch.pos_x) * PROD_W'(cfg.step_x);
         s1_prody_in = PROD_W'(req_ch.pos_y) * PROD_W'(cfg.step_y);
      end
   end

   // stage 2: source position, bounds and memory access
   assign s1_read = (s1_cmd_ff == CMD_READ);

   always_comb begin
      col = COORD_W'(cfg.offset_x) + COORD_W'(s1_prodx_ff[PROD_W-1:FRAC_W]);
      row = COORD_W'(cfg.offset_y) + COORD_W'(s1_prody_ff[PROD_W-1:FRAC_W]);
      lim_w = (COORD_W'(cfg.src_width) < COORD_W'(MAX_WIDTH)) ?
              COORD_W'(cfg.src_width) : COORD_W'(MAX_WIDTH);
      lim_h = (COORD_W'(cfg.src_height) < COORD_W'(MAX_HEIGHT)) ?
              COORD_W'(cfg.src_height) : COORD_W'(MAX_HEIGHT);
      outside = col[COORD_W-1] || row[COORD_W-1] || (col >= lim_w) || (row >= lim_h);
      wr_ok = (COORD_W'(s1_px_ff) < COORD_W'(MAX_WIDTH)) &&
              (COORD_W'(s1_py_ff) < COORD_W'(MAX_HEIGHT));
      if (s1_read) begin
         col_idx = CW'(col);
         row_idx = RW'(row);
      end else begin
         col_idx = CW'(s1_px_ff);
         row_idx = RW'(s1_py_ff);
      end
      addr   = AW'(row_idx) * AW'(MAX_WIDTH) + AW'(col_idx);
      mem_wr = move1 && !s1_read && wr_ok;
      mem_rd = move1 && s1_read && !outside;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         frame_store_ff[addr] <= s1_pix_ff;
      end
      if (mem_rd) begin
         rd_ff <= frame_store_ff[addr];
      end
   end

   always_comb begin
      s2_vld_in = s2_vld_ff && !move2;
      s2_out_in = s2_out_ff;
      if (move1) begin
         s2_vld_in = s1_read;
         s2_out_in = outside;
      end
   end

   // stage 3: format conversion into the output register
   always_comb begin
      o_vld_in = o_vld_ff && !rsp_ch.ready;
      o_out_in = o_out_ff;
      o_pix_in = o_pix_ff;
      if (move2) begin
         o_vld_in = 1'b1;
         o_out_in = s2_out_ff;
         o_pix_in = s2_out_ff ? '0 : conv_pixel(rd_ff, cfg.src_format, cfg.dst_format);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         o_vld_ff  <= o_vld_in;
      end
      s1_cmd_ff   <= s1_cmd_in;
      s1_px_ff    <= s1_px_in;
      s1_py_ff    <= s1_py_in;
      s1_pix_ff   <= s1_pix_in;
      s1_prodx_ff <= s1_prodx_in;
      s1_prody_ff <= s1_prody_in;
      s2_out_ff   <= s2_out_in;
      o_out_ff    <= o_out_in;
      o_pix_ff    <= o_pix_in;
   end

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (o_vld_ff && o_out_ff) |-> (o_pix_ff == '0))
      else $error("outside response carries non-zero pixel");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (move1 && !s1_read) |=> !s2_vld_ff)
      else $error("write transaction produced a response slot");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (move1 && s1_read) |=> s2_vld_ff)
      else $error("read transaction lost before conversion");

   a_hold_rd: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && !move2) |=> $stable(rd_ff))
      else $error("stalled read data overwritten");

endmodule

// File: hw/rtl/rfrfc_csr.sv
// ----------------------------------------------------------------------------
// Remapped frame read register file
// Holds the geometry, format and step registers written over the CSR channel.
// ----------------------------------------------------------------------------
module rfrfc_csr (
   input  logic               clock,
   input  logic               reset,
   rfrfc_csr_if.sink          csr_ch,
   output rfrfc_pkg::cfg_type cfg
);
   import rfrfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SRC_WIDTH:  cfg_in.src_width  = csr_ch.data[SIZE_W-1:0];
            REG_SRC_HEIGHT: cfg_in.src_height = csr_ch.data[SIZE_W-1:0];
            REG_SRC_FORMAT: cfg_in.src_format = csr_ch.data[FMT_W-1:0];
            REG_DST_FORMAT: cfg_in.dst_format = csr_ch.data[FMT_W-1:0];
            REG_OFFSET_X:   cfg_in.offset_x   = csr_ch.data[OFFSET_W-1:0];
            REG_OFFSET_Y:   cfg_in.offset_y   = csr_ch.data[OFFSET_W-1:0];
            REG_STEP_X:     cfg_in.step_x     = csr_ch.data[STEP_W-1:0];
            REG_STEP_Y:     cfg_in.step_y     = csr_ch.data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= RST_SRC_WIDTH;
         cfg_ff.src_height <= RST_SRC_HEIGHT;
         cfg_ff.src_format <= RST_SRC_FORMAT;
         cfg_ff.dst_format <= RST_DST_FORMAT;
         cfg_ff.offset_x   <= RST_OFFSET;
         cfg_ff.offset_y   <= RST_OFFSET;
         cfg_ff.step_x     <= RST_STEP;
         cfg_ff.step_y     <= RST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: tb/remapped_frame_read_checker.sv
// ----------------------------------------------------------------------------
// Remapped frame read checker
// Watches the request, response and register channels, keeps its own copy of
// the frame store and the settings, predicts every read response and compares
// it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module remapped_frame_read_checker (
   input  logic  clock,
   input  logic  reset,
   rfrfc_req_if  req_mon,
   rfrfc_rsp_if  rsp_mon,
   rfrfc_csr_if  csr_mon,
   output int    fail_count,
   output int    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import rfrfc_pkg::*;

   localparam logic [7:0] ZB = 8'h00;
   localparam logic [7:0] FB = 8'hFF;

   localparam int STORE_COLS = DEF_MAX_WIDTH;
   localparam int STORE_ROWS = DEF_MAX_HEIGHT;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               outside;
   } read_result_type;

   cfg_type             cfg;
   logic [PIXEL_W-1:0]  pixel_shadow [STORE_COLS*STORE_ROWS];
   read_result_type     expected_reads [$];
   int                  errors = 0;

   function automatic logic [PIXEL_W-1:0] convert_format(
      input logic [PIXEL_W-1:0] p,
      input logic [FMT_W-1:0]   from_fmt,
      input logic [FMT_W-1:0]   to_fmt
   );
      logic [7:0]         s [8];
      logic [PIXEL_W-1:0] r;
      for (int i = 0; i < 8; i++) begin
         s[i] = p[8*i +: 8];
      end
      case ({to_fmt, from_fmt})
         {FMT_3B, FMT_3B}: r = {{5{ZB}}, s[2], s[1], s[0]};
         {FMT_3B, FMT_4B}: r = {{5{ZB}}, s[3], s[2], s[1]};
         {FMT_3B, FMT_6B}: r = {{5{ZB}}, s[4], s[2], s[0]};
         {FMT_3B, FMT_8B}: r = {{5{ZB}}, s[6], s[4], s[2]};
         {FMT_4B, FMT_3B}: r = {{4{ZB}}, s[2], s[1], s[0], FB};
         {FMT_4B, FMT_4B}: r = {{4{ZB}}, s[3], s[2], s[1], s[0]};
         {FMT_4B, FMT_6B}: r = {{4{ZB}}, s[4], s[2], s[0], FB};
         {FMT_4B, FMT_8B}: r = {{4{ZB}}, s[6], s[4], s[2], s[0]};
         {FMT_6B, FMT_3B}: r = {{2{ZB}}, ZB, s[2], ZB, s[1], ZB, s[0]};
         {FMT_6B, FMT_4B}: r = {{2{ZB}}, ZB, s[3], ZB, s[2], ZB, s[1]};
         {FMT_6B, FMT_6B}: r = {{2{ZB}}, s[5], s[4], s[3], s[2], s[1], s[0]};
         {FMT_6B, FMT_8B}: r = {{2{ZB}}, s[7], s[6], s[5], s[4], s[3], s[2]};
         {FMT_8B, FMT_3B}: r = {ZB, s[2], ZB, s[1], ZB, s[0], FB, FB};
         {FMT_8B, FMT_4B}: r = {ZB, s[3], ZB, s[2], ZB, s[1], ZB, s[0]};
         {FMT_8B, FMT_6B}: r = {s[5], s[4], s[3], s[2], s[1], s[0], FB, FB};
         default:          r = p;
      endcase
      return r;
   endfunction

   function automatic read_result_type predict_read(
      input logic [POS_W-1:0] x,
      input logic [POS_W-1:0] y
   );
      logic [PROD_W-1:0] prod_x, prod_y;
      int                col, row, lim_w, lim_h;
      read_result_type   res;
      prod_x = PROD_W'(x) * PROD_W'(cfg.step_x);
      prod_y = PROD_W'(y) * PROD_W'(cfg.step_y);
      col = int'($signed(cfg.offset_x)) + int'(prod_x[PROD_W-1:FRAC_W]);
      row = int'($signed(cfg.offset_y)) + int'(prod_y[PROD_W-1:FRAC_W]);
      lim_w = (int'(cfg.src_width) < STORE_COLS) ? int'(cfg.src_width) : STORE_COLS;
      lim_h = (int'(cfg.src_height) < STORE_ROWS) ? int'(cfg.src_height) : STORE_ROWS;
      if (col < 0 || col >= lim_w || row < 0 || row >= lim_h) begin
         res.pixel   = '0;
         res.outside = 1'b1;
      end else begin
         res.pixel   = convert_format(pixel_shadow[row*STORE_COLS + col],
                                      cfg.src_format, cfg.dst_format);
         res.outside = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      read_result_type want;
      if (reset) begin
         cfg.src_width  = 9'd256;
         cfg.src_height = 9'd256;
         cfg.src_format = FMT_4B;
         cfg.dst_format = FMT_4B;
         cfg.offset_x   = 9'sd0;
         cfg.offset_y   = 9'sd0;
         cfg.step_x     = 24'h010000;
         cfg.step_y     = 24'h010000;
         expected_reads.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_reads.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, got pixel_out %h outside %b",
                        $time, rsp_mon.pixel_out, rsp_mon.outside);
            end else begin
               want = expected_reads.pop_front();
               if (rsp_mon.pixel_out !== want.pixel) begin
                  errors++;
                  $display("%0t: pixel_out expected %h, got %h",
                           $time, want.pixel, rsp_mon.pixel_out);
               end
               if (rsp_mon.outside !== want.outside) begin
                  errors++;
                  $display("%0t: outside expected %b, got %b",
                           $time, want.outside, rsp_mon.outside);
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.cmd == CMD_WRITE) begin
               pixel_shadow[int'(req_mon.pos_y)*STORE_COLS + int'(req_mon.pos_x)] =
                  req_mon.pixel_in;
            end else begin
               expected_reads.push_back(predict_read(req_mon.pos_x, req_mon.pos_y));
            end
         end
         if (csr_mon.valid === 1'b1 && csr_mon.ready === 1'b1) begin
            case (csr_mon.index)
               REG_SRC_WIDTH:  cfg.src_width  = csr_mon.data[SIZE_W-1:0];
               REG_SRC_HEIGHT: cfg.src_height = csr_mon.data[SIZE_W-1:0];
               REG_SRC_FORMAT: cfg.src_format = csr_mon.data[FMT_W-1:0];
               REG_DST_FORMAT: cfg.dst_format = csr_mon.data[FMT_W-1:0];
               REG_OFFSET_X:   cfg.offset_x   = csr_mon.data[OFFSET_W-1:0];
               REG_OFFSET_Y:   cfg.offset_y   = csr_mon.data[OFFSET_W-1:0];
               REG_STEP_X:     cfg.step_x     = csr_mon.data[STEP_W-1:0];
               REG_STEP_Y:     cfg.step_y     = csr_mon.data[STEP_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_reads.size();
      fail_count  <= errors;
   end

endmodule

// File: tb/remapped_frame_read_with_format_convert_core_test.sv
// ----------------------------------------------------------------------------
// Remapped frame read with format convert testbench
// Drives pixel writes, remapped reads and register settings into the block
// with random gaps and stalls; a checker beside the block predicts and
// compares every response. Directed corners first, then random phases.
// ----------------------------------------------------------------------------
module remapped_frame_read_with_format_convert_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rfrfc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_BASE = 4'd8;
   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 68;
   localparam int LONG_HOLD   = 200;

   localparam logic [SIZE_W-1:0]   EDGE_SIZE   [4] = '{9'd0, 9'd1, 9'd256, 9'd511};
   localparam logic [OFFSET_W-1:0] EDGE_OFFSET [4] = '{9'h100, 9'h1FF, 9'h000, 9'h0FF};
   localparam logic [STEP_W-1:0]   EDGE_STEP   [4] = '{24'd0, 24'd1, 24'h010000, 24'hFFFFFF};

   logic    clock;
   logic    reset;
   int      fail_count;
   int      reads_in_flight;
   int      req_count = 0;
   cfg_type cur_cfg;
   bit      written [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];

   rfrfc_req_if req_ch ();
   rfrfc_rsp_if rsp_ch ();
   rfrfc_csr_if csr_ch ();

   remapped_frame_read_with_format_convert_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   remapped_frame_read_checker check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .fail_count  (fail_count),
      .outstanding (reads_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int idle_gap(input int n);
      return ((n / 40) % 4 == 3) ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic [PIXEL_W-1:0] random64();
      return {$urandom, $urandom};
   endfunction

   function automatic cfg_type reset_setting();
      cfg_type c;
      c.src_width  = 9'd256;
      c.src_height = 9'd256;
      c.src_format = FMT_4B;
      c.dst_format = FMT_4B;
      c.offset_x   = 9'sd0;
      c.offset_y   = 9'sd0;
      c.step_x     = 24'h010000;
      c.step_y     = 24'h010000;
      return c;
   endfunction

   // source position a read lands on under the current setting
   function automatic bit maps_inside(
      input  logic [POS_W-1:0] x,
      input  logic [POS_W-1:0] y,
      output logic [15:0]      addr
   );
      logic [PROD_W-1:0] prod_x, prod_y;
      int                col, row, lim_w, lim_h;
      prod_x = PROD_W'(x) * PROD_W'(cur_cfg.step_x);
      prod_y = PROD_W'(y) * PROD_W'(cur_cfg.step_y);
      col = int'($signed(cur_cfg.offset_x)) + int'(prod_x[PROD_W-1:FRAC_W]);
      row = int'($signed(cur_cfg.offset_y)) + int'(prod_y[PROD_W-1:FRAC_W]);
      lim_w = (int'(cur_cfg.src_width) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
                                                         : int'(cur_cfg.src_width);
      lim_h = (int'(cur_cfg.src_height) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
                                                           : int'(cur_cfg.src_height);
      addr = {8'(row), 8'(col)};
      return (col >= 0 && col < lim_w && row >= 0 && row < lim_h);
   endfunction

   function automatic cfg_type pick_setting(output int span_x, output int span_y);
      cfg_type c;
      int      dw, dh, sx, sy;
      c = reset_setting();
      c.src_format = 2'($urandom_range(0, 3));
      c.dst_format = 2'($urandom_range(0, 3));
      span_x = 256;
      span_y = 256;
      case ($urandom_range(0, 3))
         0: begin
            c.src_width  = 9'($urandom_range(1, 256));
            c.src_height = 9'($urandom_range(1, 256));
            c.offset_x   = 9'($urandom);
            c.offset_y   = 9'($urandom);
         end
         1: begin
            c.src_width  = 9'($urandom_range(1, 256));
            c.src_height = 9'($urandom_range(1, 256));
            dw = $urandom_range(1, 256);
            dh = $urandom_range(1, 256);
            sx = (int'(c.src_width) << FRAC_W) / dw;
            sy = (int'(c.src_height) << FRAC_W) / dh;
            c.step_x = (sx > 24'hFFFFFF) ? 24'hFFFFFF : 24'(sx);
            c.step_y = (sy > 24'hFFFFFF) ? 24'hFFFFFF : 24'(sy);
            span_x = dw;
            span_y = dh;
         end
         2: begin
            c.src_width  = 9'($urandom);
            c.src_height = 9'($urandom);
            c.offset_x   = 9'($urandom);
            c.offset_y   = 9'($urandom);
            c.step_x     = 24'($urandom_range(0, 24'h040000));
            c.step_y     = 24'($urandom_range(0, 24'h040000));
         end
         default: begin
            c.src_width  = EDGE_SIZE[$urandom_range(0, 3)];
            c.src_height = EDGE_SIZE[$urandom_range(0, 3)];
            c.offset_x   = EDGE_OFFSET[$urandom_range(0, 3)];
            c.offset_y   = EDGE_OFFSET[$urandom_range(0, 3)];
            c.step_x     = EDGE_STEP[$urandom_range(0, 3)];
            c.step_y     = EDGE_STEP[$urandom_range(0, 3)];
         end
      endcase
      return c;
   endfunction

   task automatic send_req(
      input cmd_type            cmd,
      input logic [POS_W-1:0]   x,
      input logic [POS_W-1:0]   y,
      input logic [PIXEL_W-1:0] pix
   );
      int gap;
      gap = idle_gap(req_count);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.pos_x    <= x;
      req_ch.pos_y    <= y;
      req_ch.pixel_in <= pix;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      req_count++;
      if (cmd == CMD_WRITE) begin
         written[{y, x}] = 1'b1;
      end
   endtask

   // fill the mapped source entry first when it has never been written
   task automatic read_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      logic [15:0] addr;
      if (maps_inside(x, y, addr) && !written[addr]) begin
         send_req(CMD_WRITE, addr[7:0], addr[15:8], random64());
      end
      send_req(CMD_READ, x, y, random64());
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (reads_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   task automatic apply_cfg(input cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      drain();
      junk = CSR_DATA_W'($urandom);
      write_reg(REG_SRC_WIDTH,  {junk[23:9], c.src_width});
      write_reg(REG_SRC_HEIGHT, {junk[23:9], c.src_height});
      write_reg(REG_SRC_FORMAT, {junk[23:2], c.src_format});
      write_reg(REG_DST_FORMAT, {junk[23:2], c.dst_format});
      write_reg(REG_OFFSET_X,   {junk[23:9], c.offset_x});
      write_reg(REG_OFFSET_Y,   {junk[23:9], c.offset_y});
      write_reg(REG_STEP_X,     c.step_x);
      write_reg(REG_STEP_Y,     c.step_y);
      write_reg(REG_UNUSED_BASE | CSR_IDX_W'($urandom_range(0, 7)), ~junk);
      csr_ch.valid <= 1'b0;
      cur_cfg = c;
      @(posedge clock);
   endtask

   initial begin : rsp_side
      int gap;
      int served;
      served = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = idle_gap(served);
         if (served == 60 || served == 300) begin
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         served++;
      end
   end

   initial begin : stimulus
      cfg_type c;
      cfg_type base;
      int      span_x, span_y, pick;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_WRITE;
      req_ch.pos_x    <= '0;
      req_ch.pos_y    <= '0;
      req_ch.pixel_in <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= REG_SRC_WIDTH;
      csr_ch.data     <= '0;
      base = reset_setting();
      cur_cfg = base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // corners under the reset setting, then a write followed at once by its read
      send_req(CMD_WRITE, 8'd0, 8'd0, '1);
      send_req(CMD_WRITE, 8'd255, 8'd255, '0);
      send_req(CMD_WRITE, 8'd255, 8'd0, 64'h8877_6655_4433_2211);
      read_pixel(8'd0, 8'd0);
      read_pixel(8'd255, 8'd255);
      read_pixel(8'd255, 8'd0);
      send_req(CMD_WRITE, 8'd17, 8'd42, random64());
      read_pixel(8'd17, 8'd42);

      for (int s = 0; s < 4; s++) begin
         for (int d = 0; d < 4; d++) begin
            c = base;
            c.src_format = 2'(s);
            c.dst_format = 2'(d);
            apply_cfg(c);
            read_pixel(8'd255, 8'd0);
         end
      end

      // most negative offset with the largest step
      c = base;
      c.offset_x = 9'h100;
      c.step_x   = 24'hFFFFFF;
      apply_cfg(c);
      read_pixel(8'd1, 8'd0);
      read_pixel(8'd2, 8'd0);

      // zero width
      c = base;
      c.src_width = 9'd0;
      apply_cfg(c);
      read_pixel(8'd0, 8'd0);

      // sizes beyond the store, largest positive offsets
      c = base;
      c.src_width  = 9'h1FF;
      c.src_height = 9'h1FF;
      c.offset_x   = 9'h0FF;
      c.offset_y   = 9'h0FF;
      apply_cfg(c);
      read_pixel(8'd0, 8'd0);
      read_pixel(8'd1, 8'd0);

      // row offset of minus one
      c = base;
      c.offset_y = 9'h1FF;
      apply_cfg(c);
      read_pixel(8'd0, 8'd0);

      for (int p = 0; p < PHASES; p++) begin
         c = pick_setting(span_x, span_y);
         apply_cfg(c);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_req(CMD_WRITE, 8'($urandom), 8'($urandom), random64());
            end else if (pick < 90) begin
               read_pixel(8'($urandom_range(0, span_x - 1)),
                          8'($urandom_range(0, span_y - 1)));
            end else begin
               read_pixel(8'($urandom), 8'($urandom));
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
